[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros used by the flow table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/bft_pkg.sv]
// ----------------------------------------------------------------------------
// bft_pkg
// Types and codes shared by the bidirectional flow table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bft_pkg;

    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] ST_HIT        = 3'd0;
    localparam logic [2:0] ST_NEW        = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_READ_OK    = 3'd3;
    localparam logic [2:0] ST_READ_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        ip_version;
        logic [63:0] src_ip_hi;
        logic [63:0] src_ip_lo;
        logic [63:0] dst_ip_hi;
        logic [63:0] dst_ip_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [15:0] pkt_len;
        logic [63:0] time_us;
        logic [5:0]  entry_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  flow_index;
        logic        direction;
        logic [7:0]  flow_protocol;
        logic [47:0] pkt_total;
        logic [63:0] byte_total;
        logic [47:0] packets_forward;
        logic [63:0] bytes_forward;
        logic [47:0] packets_reverse;
        logic [63:0] bytes_reverse;
        logic [63:0] flow_start;
        logic [63:0] flow_end;
    } t_out;

    // Key part of a slot: everything the lookup compares.
    typedef struct packed {
        logic        is_v6;
        logic [7:0]  proto;
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic [63:0] b_hi;
        logic [63:0] b_lo;
        logic [15:0] port_a;
        logic [15:0] port_b;
    } t_key;

    // Statistics part of a slot.
    typedef struct packed {
        logic [47:0] pkt_fwd;
        logic [47:0] pkt_rev;
        logic [63:0] byte_fwd;
        logic [63:0] byte_rev;
        logic [63:0] first;
        logic [63:0] last;
    } t_stats;

    // Outcome of comparing one stored key against the packet.
    typedef struct packed {
        logic hit;
        logic dir;
    } t_match;

endpackage

[sv/bidirectional_flow_table.sv]
// ----------------------------------------------------------------------------
// bidirectional_flow_table
// Bounded five-tuple flow table with per-direction counters.
// ----------------------------------------------------------------------------
// A packet update walks the table one slot per cycle, comparing the packet
// against each stored key through a single shared compare unit. A miss scans
// every slot, drains the last key read, then writes back, reads the
// statistics and registers the result; a hit stops the scan early and reads
// the hit slot's statistics before the write back. A read of a valid slot
// goes through a memory read first, while a read of an empty slot, a clear
// and the unused request kind go straight to the result. After each result
// the block returns to idle before it can accept again. Keys and statistics
// live in two memories with one write and one registered read port each;
// only the valid bits sit in flip-flops, so a clear drops them all at once.
// The block handles one request at a time: o_in_ready is high only while the
// sequencer is idle. The result sits in an output register, and the next
// request is accepted while it waits; that request holds its own result until
// the register is free. Unwritten memory entries are never exposed because
// only a slot whose valid bit is set can match or be reported.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bidirectional_flow_table #(
    parameter int FLOW_ENTRIES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bft_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bft_pkg::t_out   o_out_data
);
    localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = IW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_STAT  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_RDOUT = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_BLANK = 3'd7;

    bft_pkg::t_key   r_key_mem [FLOW_ENTRIES];
    bft_pkg::t_stats r_stat_mem[FLOW_ENTRIES];
    logic [FLOW_ENTRIES-1:0] r_valid;

    logic [2:0]      r_state;
    bft_pkg::t_in    r_req;
    logic [CW-1:0]   r_addr;      // address presented to the key memory
    logic [CW-1:0]   r_cmp_idx;   // slot whose key is in r_key_q
    logic            r_cmp_live;
    bft_pkg::t_key   r_key_q;
    bft_pkg::t_stats r_stat_q;
    logic [IW-1:0]   r_sel;
    logic            r_dir;
    logic            r_found;
    logic            r_free_ok;
    logic [IW-1:0]   r_free_idx;
    logic            r_out_valid;
    bft_pkg::t_out   r_out;
    bft_pkg::t_out   n_out;

    logic            w_v6;
    logic [63:0]     w_shi, w_slo, w_dhi, w_dlo;
    bft_pkg::t_match w_m;
    logic            w_cmp_hit;
    logic [IW-1:0]   w_cmp_slot;
    bft_pkg::t_stats w_upd;
    logic            w_out_free;
    logic            w_out_load;

    assign w_v6  = r_req.ip_version;
    assign w_shi = w_v6 ? r_req.src_ip_hi : '0;
    assign w_slo = w_v6 ? r_req.src_ip_lo : {32'd0, r_req.src_ip_lo[31:0]};
    assign w_dhi = w_v6 ? r_req.dst_ip_hi : '0;
    assign w_dlo = w_v6 ? r_req.dst_ip_lo : {32'd0, r_req.dst_ip_lo[31:0]};

    bft_match u_match (
        .i_key   (r_key_q),
        .i_v6    (w_v6),
        .i_proto (r_req.protocol),
        .i_shi   (w_shi),
        .i_slo   (w_slo),
        .i_dhi   (w_dhi),
        .i_dlo   (w_dlo),
        .i_sp    (r_req.src_port),
        .i_dp    (r_req.dst_port),
        .o_match (w_m)
    );

    assign w_cmp_slot = r_cmp_idx[IW-1:0];
    assign w_cmp_hit  = r_cmp_live && r_valid[w_cmp_slot] && w_m.hit;

    // A finished request loads the output register once it is empty or
    // being drained in the same cycle.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = w_out_free && ((r_state == S_RDOUT) || (r_state == S_EMIT)
                                        || (r_state == S_BLANK));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Counter update for a hit on the selected slot.
    always_comb begin
        w_upd      = r_stat_q;
        w_upd.last = r_req.time_us;
        if (!r_dir) begin
            w_upd.pkt_fwd  = r_stat_q.pkt_fwd + 48'd1;
            w_upd.byte_fwd = r_stat_q.byte_fwd + {48'd0, r_req.pkt_len};
        end else begin
            w_upd.pkt_rev  = r_stat_q.pkt_rev + 48'd1;
            w_upd.byte_rev = r_stat_q.byte_rev + {48'd0, r_req.pkt_len};
        end
    end

    // Key memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && !r_found && r_free_ok) begin
            r_key_mem[r_free_idx] <= '{is_v6: w_v6, proto: r_req.protocol,
                                       a_hi: w_shi, a_lo: w_slo, b_hi: w_dhi, b_lo: w_dlo,
                                       port_a: r_req.src_port, port_b: r_req.dst_port};
        end
        r_key_q <= r_key_mem[r_addr[IW-1:0]];
    end

    // Statistics memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            if (r_found) begin
                r_stat_mem[r_sel] <= w_upd;
            end else if (r_free_ok) begin
                r_stat_mem[r_free_idx] <= '{pkt_fwd: 48'd1, pkt_rev: '0,
                                            byte_fwd: {48'd0, r_req.pkt_len},
                                            byte_rev: '0, first: r_req.time_us,
                                            last: r_req.time_us};
            end
        end
        r_stat_q <= r_stat_mem[r_sel];
    end

    // Result assembly from a slot's statistics.
    function automatic bft_pkg::t_out f_slot(input logic [2:0] st, input logic [5:0] idx,
                                             input logic dir, input logic [7:0] proto,
                                             input bft_pkg::t_stats s);
        bft_pkg::t_out o;
        o.status          = st;
        o.flow_index      = idx;
        o.direction       = dir;
        o.flow_protocol   = proto;
        o.pkt_total       = s.pkt_fwd + s.pkt_rev;
        o.byte_total      = s.byte_fwd + s.byte_rev;
        o.packets_forward = s.pkt_fwd;
        o.bytes_forward   = s.byte_fwd;
        o.packets_reverse = s.pkt_rev;
        o.bytes_reverse   = s.byte_rev;
        o.flow_start      = s.first;
        o.flow_end        = s.last;
        return o;
    endfunction

    always_comb begin
        n_out = '0;
        unique case (r_state)
            S_RDOUT: begin
                n_out = f_slot(bft_pkg::ST_READ_OK, r_req.entry_index, 1'b0,
                               r_key_q.proto, r_stat_q);
            end
            S_EMIT: begin
                if (r_found) begin
                    n_out = f_slot(bft_pkg::ST_HIT, 6'(r_sel), r_dir, r_key_q.proto,
                                   r_stat_q);
                end else if (r_free_ok) begin
                    n_out = f_slot(bft_pkg::ST_NEW, 6'(r_free_idx), 1'b0,
                                   r_req.protocol, r_stat_q);
                end else begin
                    n_out.status = bft_pkg::ST_FULL;
                end
            end
            S_BLANK: begin
                // Empty-slot reads echo the index; clears and the unused kind do not.
                if (r_req.req_type == bft_pkg::REQ_READ) begin
                    n_out.status     = bft_pkg::ST_READ_EMPTY;
                    n_out.flow_index = r_req.entry_index;
                end else begin
                    n_out.status = bft_pkg::ST_READ_OK;
                end
            end
            default: n_out = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
            r_out       <= n_out;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_cmp_live <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cmp_live <= 1'b0;
                    if (i_in_valid) begin
                        r_req      <= i_in_data;
                        r_found    <= 1'b0;
                        r_free_ok  <= 1'b0;
                        r_free_idx <= '0;
                        case (i_in_data.req_type)
                            bft_pkg::REQ_PACKET: begin
                                r_addr  <= '0;
                                r_state <= S_SCAN;
                            end
                            bft_pkg::REQ_READ: begin
                                if ({{(32-6){1'b0}}, i_in_data.entry_index} < FLOW_ENTRIES
                                    && r_valid[IW'(i_in_data.entry_index)]) begin
                                    r_addr  <= CW'(i_in_data.entry_index);
                                    r_sel   <= IW'(i_in_data.entry_index);
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_BLANK;
                                end
                            end
                            default: begin
                                if (i_in_data.req_type == bft_pkg::REQ_CLEAR) begin
                                    r_valid <= '0;
                                end
                                r_state <= S_BLANK;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Stage 1 presents r_addr; stage 2 compares the key read back.
                    r_cmp_idx <= r_addr;
                    if (r_addr < CW'(FLOW_ENTRIES) && !r_valid[r_addr[IW-1:0]]
                        && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_addr[IW-1:0];
                    end
                    if (w_cmp_hit) begin
                        r_found    <= 1'b1;
                        r_sel      <= w_cmp_slot;
                        r_dir      <= w_m.dir;
                        r_cmp_live <= 1'b0;
                        r_addr     <= r_cmp_idx;
                        r_state    <= S_STAT;
                    end else begin
                        r_cmp_live <= r_addr < CW'(FLOW_ENTRIES);
                        if (r_addr < CW'(FLOW_ENTRIES)) begin
                            r_addr <= r_addr + CW'(1);
                        end
                        if (r_cmp_live && r_cmp_idx == CW'(FLOW_ENTRIES - 1)) begin
                            r_sel   <= r_free_idx;
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_STAT: r_state <= S_WRITE;   // statistics read of the hit slot
                S_WRITE: begin
                    if (!r_found && r_free_ok) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_state <= S_READ;
                end
                S_READ:  r_state <= (r_req.req_type == bft_pkg::REQ_READ) ? S_RDOUT : S_EMIT;
                S_RDOUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_BLANK: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !w_out_load)
    `ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, r_state == S_EMIT, o_out_valid)
    `ASSERT_IMPL(a_write_has_slot, i_clk, i_rst_n, r_state == S_WRITE && r_found,
                 r_valid[r_sel])
endmodule

[sv/bft_match.sv]
// ----------------------------------------------------------------------------
// bft_match
// Compares one stored flow key against a packet in both directions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bft_match (
    input  bft_pkg::t_key   i_key,
    input  logic            i_v6,
    input  logic [7:0]      i_proto,
    input  logic [63:0]     i_shi,
    input  logic [63:0]     i_slo,
    input  logic [63:0]     i_dhi,
    input  logic [63:0]     i_dlo,
    input  logic [15:0]     i_sp,
    input  logic [15:0]     i_dp,
    output bft_pkg::t_match o_match
);
    logic [63:0] w_hmask;
    logic [63:0] w_lmask;
    logic        w_src_a, w_src_b, w_dst_a, w_dst_b, w_kind;

    // IPv4 compares the low 32 bits of the low word only.
    assign w_hmask = i_v6 ? '1 : '0;
    assign w_lmask = i_v6 ? '1 : {32'd0, 32'hFFFF_FFFF};

    assign w_kind  = (i_key.proto == i_proto) && (i_key.is_v6 == i_v6);
    assign w_src_a = (((i_shi ^ i_key.a_hi) & w_hmask) == '0)
                  && (((i_slo ^ i_key.a_lo) & w_lmask) == '0) && (i_sp == i_key.port_a);
    assign w_src_b = (((i_shi ^ i_key.b_hi) & w_hmask) == '0)
                  && (((i_slo ^ i_key.b_lo) & w_lmask) == '0) && (i_sp == i_key.port_b);
    assign w_dst_a = (((i_dhi ^ i_key.a_hi) & w_hmask) == '0)
                  && (((i_dlo ^ i_key.a_lo) & w_lmask) == '0) && (i_dp == i_key.port_a);
    assign w_dst_b = (((i_dhi ^ i_key.b_hi) & w_hmask) == '0)
                  && (((i_dlo ^ i_key.b_lo) & w_lmask) == '0) && (i_dp == i_key.port_b);

    assign o_match.hit = w_kind && ((w_src_a && w_dst_b) || (w_src_b && w_dst_a));
    assign o_match.dir = !w_src_a;
endmodule

[sim/tb_bidirectional_flow_table.sv]
// ----------------------------------------------------------------------------
// tb_bidirectional_flow_table
// Self-checking bench for the bidirectional flow table: directed table, then
// random packet traffic over a small pool of flows, checked by a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_bidirectional_flow_table;

    localparam int SLOTS      = 64;
    localparam int N_RANDOM   = 820;
    localparam int CYCLE_CAP  = 400000;
    localparam int POOL       = 80;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    bft_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    bft_pkg::t_out  o_out_data;

    bidirectional_flow_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The clock runs at a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Mirror of the flow table kept by the bench.
    logic        fl_valid [SLOTS];
    logic        fl_v6    [SLOTS];
    logic [7:0]  fl_proto [SLOTS];
    logic [63:0] fl_ahi [SLOTS], fl_alo [SLOTS], fl_bhi [SLOTS], fl_blo [SLOTS];
    logic [15:0] fl_pa [SLOTS], fl_pb [SLOTS];
    logic [47:0] fl_pf [SLOTS], fl_pr [SLOTS];
    logic [63:0] fl_bf [SLOTS], fl_br [SLOTS], fl_first [SLOTS], fl_last [SLOTS];

    bft_pkg::t_out expected_results[$];
    int   errors;
    bit   quiet;      // No idling in the last part of the run.

    function automatic bft_pkg::t_out slot_report(logic [2:0] st, int idx, logic dir);
        bft_pkg::t_out r;
        r                 = '0;
        r.status          = st;
        r.flow_index      = idx[5:0];
        r.direction       = dir;
        r.flow_protocol   = fl_proto[idx];
        r.pkt_total       = fl_pf[idx] + fl_pr[idx];
        r.byte_total      = fl_bf[idx] + fl_br[idx];
        r.packets_forward = fl_pf[idx];
        r.bytes_forward   = fl_bf[idx];
        r.packets_reverse = fl_pr[idx];
        r.bytes_reverse   = fl_br[idx];
        r.flow_start      = fl_first[idx];
        r.flow_end        = fl_last[idx];
        return r;
    endfunction

    // Computes the result of one request and advances the mirrored table.
    function automatic bft_pkg::t_out track_flow(bft_pkg::t_in q);
        bft_pkg::t_out r;
        logic [63:0]   shi, slo, dhi, dlo;
        logic          sa, sb, da, db, v6;
        int            free_slot;
        r = '0;
        if (q.req_type == bft_pkg::REQ_PACKET) begin
            v6  = q.ip_version;
            shi = v6 ? q.src_ip_hi : 64'd0;
            slo = v6 ? q.src_ip_lo : {32'd0, q.src_ip_lo[31:0]};
            dhi = v6 ? q.dst_ip_hi : 64'd0;
            dlo = v6 ? q.dst_ip_lo : {32'd0, q.dst_ip_lo[31:0]};
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!fl_valid[i]) begin
                    if (free_slot < 0) free_slot = i;
                    continue;
                end
                if (fl_proto[i] != q.protocol || fl_v6[i] != v6) continue;
                sa = shi == fl_ahi[i] && slo == fl_alo[i] && q.src_port == fl_pa[i];
                sb = shi == fl_bhi[i] && slo == fl_blo[i] && q.src_port == fl_pb[i];
                da = dhi == fl_ahi[i] && dlo == fl_alo[i] && q.dst_port == fl_pa[i];
                db = dhi == fl_bhi[i] && dlo == fl_blo[i] && q.dst_port == fl_pb[i];
                if ((sa && db) || (sb && da)) begin
                    fl_last[i] = q.time_us;
                    if (sa) begin
                        fl_pf[i] = fl_pf[i] + 48'd1;
                        fl_bf[i] = fl_bf[i] + {48'd0, q.pkt_len};
                    end else begin
                        fl_pr[i] = fl_pr[i] + 48'd1;
                        fl_br[i] = fl_br[i] + {48'd0, q.pkt_len};
                    end
                    return slot_report(bft_pkg::ST_HIT, i, !sa);
                end
            end
            if (free_slot < 0) begin
                r.status = bft_pkg::ST_FULL;
                return r;
            end
            fl_valid[free_slot] = 1'b1;
            fl_v6[free_slot]    = v6;
            fl_proto[free_slot] = q.protocol;
            fl_ahi[free_slot]   = shi;
            fl_alo[free_slot]   = slo;
            fl_bhi[free_slot]   = dhi;
            fl_blo[free_slot]   = dlo;
            fl_pa[free_slot]    = q.src_port;
            fl_pb[free_slot]    = q.dst_port;
            fl_pf[free_slot]    = 48'd1;
            fl_bf[free_slot]    = {48'd0, q.pkt_len};
            fl_pr[free_slot]    = '0;
            fl_br[free_slot]    = '0;
            fl_first[free_slot] = q.time_us;
            fl_last[free_slot]  = q.time_us;
            return slot_report(bft_pkg::ST_NEW, free_slot, 1'b0);
        end
        if (q.req_type == bft_pkg::REQ_READ) begin
            if (fl_valid[q.entry_index]) begin
                return slot_report(bft_pkg::ST_READ_OK, int'(q.entry_index), 1'b0);
            end
            r.status     = bft_pkg::ST_READ_EMPTY;
            r.flow_index = q.entry_index;
            return r;
        end
        // A clear and the unused request kind both answer with a bare status.
        if (q.req_type == bft_pkg::REQ_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) fl_valid[i] = 1'b0;
        end
        r.status = bft_pkg::ST_READ_OK;
        return r;
    endfunction

    // Pool of flow endpoints so that random packets hit existing flows often.
    bft_pkg::t_in flow_pool[POOL];

    function automatic bft_pkg::t_in random_header();
        bft_pkg::t_in q;
        q.req_type    = bft_pkg::REQ_PACKET;
        q.ip_version  = 1'($urandom_range(0, 1));
        q.src_ip_hi   = {$urandom, $urandom};
        q.src_ip_lo   = {$urandom, $urandom};
        q.dst_ip_hi   = {$urandom, $urandom};
        q.dst_ip_lo   = {$urandom, $urandom};
        q.src_port    = 16'($urandom);
        q.dst_port    = 16'($urandom);
        q.protocol    = 8'($urandom);
        q.pkt_len     = 16'($urandom);
        q.time_us     = {$urandom, $urandom};
        q.entry_index = 6'($urandom);
        return q;
    endfunction

    // Builds one random beat: mostly packets of pooled flows in either
    // direction, with reads, occasional clears and fully random noise.
    function automatic bft_pkg::t_in pick_request();
        bft_pkg::t_in q;
        int           roll;
        roll = $urandom_range(0, 99);
        q    = random_header();
        if (roll < 70) begin
            bft_pkg::t_in f;
            f = flow_pool[$urandom_range(0, POOL - 1)];
            q.ip_version = f.ip_version;
            q.protocol   = f.protocol;
            if ($urandom_range(0, 1)) begin
                q.src_ip_hi = f.src_ip_hi; q.src_ip_lo = f.src_ip_lo;
                q.dst_ip_hi = f.dst_ip_hi; q.dst_ip_lo = f.dst_ip_lo;
                q.src_port  = f.src_port;  q.dst_port  = f.dst_port;
            end else begin
                q.src_ip_hi = f.dst_ip_hi; q.src_ip_lo = f.dst_ip_lo;
                q.dst_ip_hi = f.src_ip_hi; q.dst_ip_lo = f.src_ip_lo;
                q.src_port  = f.dst_port;  q.dst_port  = f.src_port;
            end
            // For IPv4 the upper address bits must be ignored, so scramble them.
            if (!q.ip_version) begin
                q.src_ip_hi = {$urandom, $urandom};
                q.src_ip_lo[63:32] = $urandom;
                q.dst_ip_hi = {$urandom, $urandom};
                q.dst_ip_lo[63:32] = $urandom;
            end
        end else if (roll < 88) begin
            q.req_type = bft_pkg::REQ_READ;
        end else if (roll < 90) begin
            q.req_type = bft_pkg::REQ_CLEAR;
        end else if (roll < 91) begin
            q.req_type = bft_pkg::REQ_UNUSED;
        end
        return q;
    endfunction

    // Directed table: each row is a request and, where obvious, its result.
    typedef struct {
        bft_pkg::t_in  req;
        bit            typed;
        bft_pkg::t_out res;
    } t_row;
    t_row script[$];

    bft_pkg::t_in flow_fill[$];
    bft_pkg::t_in overflow_req;

    function automatic bft_pkg::t_out blank_result(logic [2:0] st, logic [5:0] idx);
        bft_pkg::t_out r;
        r            = '0;
        r.status     = st;
        r.flow_index = idx;
        return r;
    endfunction

    task automatic add_row(bft_pkg::t_in q, bit typed, bft_pkg::t_out r);
        t_row row;
        row.req   = q;
        row.typed = typed;
        row.res   = r;
        script.push_back(row);
    endtask

    task automatic build_script();
        bft_pkg::t_in q, b;
        // Reads of an empty table at both index extremes.
        q = '0; q.req_type = bft_pkg::REQ_READ; q.entry_index = 6'd0;
        add_row(q, 1, blank_result(bft_pkg::ST_READ_EMPTY, 6'd0));
        q.entry_index = 6'd63;
        add_row(q, 1, blank_result(bft_pkg::ST_READ_EMPTY, 6'd63));
        // First flow: all-ones IPv6 fields.
        b = '1; b.req_type = bft_pkg::REQ_PACKET; b.ip_version = 1'b1;
        add_row(b, 0, '0);
        // Same flow again, then two new flows, each with part of one endpoint cleared.
        add_row(b, 0, '0);
        q = b; q.src_ip_lo = 64'd0; q.src_port = 16'd0;
        add_row(q, 0, '0);                       // new flow
        q = b; q.src_ip_lo = b.dst_ip_lo; q.dst_ip_lo = 64'd0;
        add_row(q, 0, '0);
        // IPv4 flow with upper bits set; the reverse packet has other upper bits.
        q = '0; q.ip_version = 1'b0; q.src_ip_lo = 64'hFFFF_FFFF_1234_5678;
        q.dst_ip_lo = 64'h0000_0001_8765_4321; q.src_ip_hi = '1;
        q.src_port = 16'd80; q.dst_port = 16'd443; q.protocol = 8'd6;
        q.pkt_len = 16'hFFFF; q.time_us = 64'd5;
        add_row(q, 0, '0);
        b = q; b.src_ip_lo = 64'hAAAA_0000_8765_4321; b.dst_ip_lo = 64'h1234_5678;
        b.src_port = 16'd443; b.dst_port = 16'd80; b.dst_ip_hi = 64'd7; b.time_us = '1;
        add_row(b, 0, '0);
        // Same packets otherwise, but IPv6 and other protocol: both new flows.
        b.ip_version = 1'b1; add_row(b, 0, '0);
        q.protocol = 8'd17; add_row(q, 0, '0);
        // Same endpoint on both sides counts as A to B.
        q = '0; q.ip_version = 1'b1; q.src_ip_hi = 64'h55; q.dst_ip_hi = 64'h55;
        q.src_port = 16'h1111; q.dst_port = 16'h1111; q.protocol = 8'd1;
        add_row(q, 0, '0);
        add_row(q, 0, '0);
        // Reads of valid and empty slots, the unused request kind, a clear and a read.
        q = '0; q.req_type = bft_pkg::REQ_READ; q.entry_index = 6'd1;
        add_row(q, 0, '0);
        q.entry_index = 6'd40; add_row(q, 1, blank_result(bft_pkg::ST_READ_EMPTY, 6'd40));
        q = '1; q.req_type = bft_pkg::REQ_UNUSED;
        add_row(q, 1, blank_result(bft_pkg::ST_READ_OK, 6'd0));
        q = '0; q.req_type = bft_pkg::REQ_CLEAR;
        add_row(q, 1, blank_result(bft_pkg::ST_READ_OK, 6'd0));
        q = '0; q.req_type = bft_pkg::REQ_READ; q.entry_index = 6'd0;
        add_row(q, 1, blank_result(bft_pkg::ST_READ_EMPTY, 6'd0));
        // Fill the table with distinct flows, then overflow it.
        for (int i = 0; i < SLOTS; i++) begin
            q = '0; q.ip_version = 1'b0; q.src_ip_lo = 64'(i); q.protocol = 8'd6;
            q.pkt_len = 16'(i); q.time_us = 64'(i);
            if (i < SLOTS - 1) begin
                flow_fill.push_back(q);
            end else begin
                add_row(q, 0, '0);
            end
        end
        q.src_ip_lo = 64'd999;
        overflow_req = q;
    endtask

    // Drives one beat and waits for its acceptance; returns at the falling
    // edge after it, where the caller drives the next beat or drops valid.
    task automatic send_beat(bft_pkg::t_in q);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_data  <= q;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(track_flow(q));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    // Result side: random stall bursts, then check every accepted beat.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        stall       = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 16) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out_data);
                errors++;
            end else begin
                bft_pkg::t_out e;
                e = expected_results.pop_front();
                if (o_out_data.status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.flow_index !== e.flow_index) begin
                    $error("flow_index expected %0d got %0d", e.flow_index,
                           o_out_data.flow_index);
                    errors++;
                end
                if (o_out_data.direction !== e.direction) begin
                    $error("direction expected %0d got %0d", e.direction,
                           o_out_data.direction);
                    errors++;
                end
                if (o_out_data.flow_protocol !== e.flow_protocol) begin
                    $error("flow_protocol expected %0d got %0d", e.flow_protocol,
                           o_out_data.flow_protocol);
                    errors++;
                end
                if (o_out_data.pkt_total !== e.pkt_total) begin
                    $error("pkt_total expected %0h got %0h", e.pkt_total,
                           o_out_data.pkt_total);
                    errors++;
                end
                if (o_out_data.byte_total !== e.byte_total) begin
                    $error("byte_total expected %0h got %0h", e.byte_total,
                           o_out_data.byte_total);
                    errors++;
                end
                if (o_out_data.packets_forward !== e.packets_forward) begin
                    $error("packets_forward expected %0h got %0h", e.packets_forward,
                           o_out_data.packets_forward);
                    errors++;
                end
                if (o_out_data.bytes_forward !== e.bytes_forward) begin
                    $error("bytes_forward expected %0h got %0h", e.bytes_forward,
                           o_out_data.bytes_forward);
                    errors++;
                end
                if (o_out_data.packets_reverse !== e.packets_reverse) begin
                    $error("packets_reverse expected %0h got %0h", e.packets_reverse,
                           o_out_data.packets_reverse);
                    errors++;
                end
                if (o_out_data.bytes_reverse !== e.bytes_reverse) begin
                    $error("bytes_reverse expected %0h got %0h", e.bytes_reverse,
                           o_out_data.bytes_reverse);
                    errors++;
                end
                if (o_out_data.flow_start !== e.flow_start) begin
                    $error("flow_start expected %0h got %0h", e.flow_start,
                           o_out_data.flow_start);
                    errors++;
                end
                if (o_out_data.flow_end !== e.flow_end) begin
                    $error("flow_end expected %0h got %0h", e.flow_end,
                           o_out_data.flow_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[bidirectional_flow_table] ERROR");
        $finish;
    end

    // Main sequence.
    initial begin
        bft_pkg::t_in q;
        errors     = 0;
        quiet      = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        for (int i = 0; i < SLOTS; i++) fl_valid[i] = 1'b0;
        for (int i = 0; i < POOL; i++) flow_pool[i] = random_header();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; a typed result in a row is also compared with the
        // predictor, so the two can never silently disagree.
        build_script();
        foreach (script[k]) begin
            send_beat(script[k].req);
            if (script[k].typed && expected_results[$] != script[k].res) begin
                $error("directed row %0d: predictor gives status %0d, table says %0d",
                       k, expected_results[$].status, script[k].res.status);
                errors++;
            end
        end
        // Fill the remaining slots, then a packet of a new flow is dropped.
        foreach (flow_fill[k]) send_beat(flow_fill[k]);
        send_beat(overflow_req);
        if (expected_results[$] != blank_result(bft_pkg::ST_FULL, 6'd0)) begin
            $error("status expected %0d for a full table", bft_pkg::ST_FULL);
            errors++;
        end

        // Hold the sender until every result is back, then clear the table.
        wait_drained();
        q = '0; q.req_type = bft_pkg::REQ_CLEAR;
        send_beat(q);

        // Random part; the last tenth runs with no idling on either side.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM * 9 / 10) quiet = 1'b1;
            if (n == N_RANDOM / 2) wait_drained();
            send_beat(pick_request());
        end

        wait_drained();
        repeat (SLOTS + 10) @(negedge i_clk);
        if (errors == 0) begin
            $display("[bidirectional_flow_table] OK");
        end else begin
            $display("[bidirectional_flow_table] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/bft_pkg.sv
sv/bft_match.sv
sv/bidirectional_flow_table.sv
sim/tb_bidirectional_flow_table.sv
